### hdl/multi_uart_transceiver_assert.svh
`ifndef MULTI_UART_TRANSCEIVER_ASSERT_SVH
`define MULTI_UART_TRANSCEIVER_ASSERT_SVH

// Assertion shorthands for the transceiver checker.
// Both expect clk and arst_n to be visible where they are used.

// Consequent must hold in the same cycle as the antecedent
`define MUART_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("multi_uart_transceiver: assertion failed");

// Consequent must hold in the cycle after the antecedent
`define MUART_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("multi_uart_transceiver: assertion failed");

`endif

### hdl/muart_pkg.sv
`timescale 1ns / 1ps

package muart_pkg;

	// Fixed field widths
	localparam int LINE_W = 12;
	localparam int CHAN_W = 4;
	localparam int BYTE_W = 8;
	localparam int RX_W   = 11;
	localparam int TX_W   = 10;

	// Request codes on the input
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_QUEUE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_QUERY = 2'd3;

	// Frame constants
	localparam logic [RX_W-1:0] RX_MARKER = 11'h400;
	localparam logic [TX_W-1:0] TX_IDLE   = 10'h001;

	// Phase counter
	localparam logic [1:0] PHASE_LAST = 2'd2;

	// Depths of the decoupling queues
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [CHAN_W-1:0] channel;
		logic [BYTE_W-1:0] tx_byte;
		logic [LINE_W-1:0] line_in;
	} in_item_t;

	typedef struct packed {
		logic [LINE_W-1:0] rx_done_mask;
		logic [LINE_W-1:0] line_out;
		logic              line_out_valid;
		logic [BYTE_W-1:0] rx_byte;
		logic              rx_valid;
		logic              tx_ready;
	} out_item_t;

	// Classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_TICK,
		OP_QUEUE,
		OP_READ,
		OP_QUERY,
		OP_NULL
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CHAN_W-1:0] chan;
		logic [LINE_W-1:0] arg;
	} cmd_t;

endpackage

### hdl/muart_fifo.sv
`timescale 1ns / 1ps

module muart_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### hdl/muart_front.sv
`timescale 1ns / 1ps

module muart_front import muart_pkg::*; #(
	parameter int CHANNELS = 12
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t item,
	output logic     full,
	output logic     cmd_valid,
	output cmd_t     cmd,
	input  logic     cmd_pop
);

	cmd_t cmd_w;
	logic chan_ok;
	logic cmd_empty;
	logic [$bits(cmd_t)-1:0] cmd_bits;

	// Queue, read and query requests to a channel that does not exist do nothing but return zeros
	assign chan_ok = ({1'b0, item.channel} < (CHAN_W + 1)'(CHANNELS));

	// Classify the request
	always_comb begin
		cmd_w.chan = item.channel;
		cmd_w.arg  = '0;
		case (item.req_type)
			REQ_TICK: begin
				cmd_w.op  = OP_TICK;
				cmd_w.arg = item.line_in;
			end
			REQ_QUEUE: begin
				cmd_w.op  = chan_ok ? OP_QUEUE : OP_NULL;
				cmd_w.arg = LINE_W'(item.tx_byte);
			end
			REQ_READ:  cmd_w.op = chan_ok ? OP_READ : OP_NULL;
			REQ_QUERY: cmd_w.op = chan_ok ? OP_QUERY : OP_NULL;
			default:   cmd_w.op = OP_NULL;
		endcase
	end

	// Command queue towards the execution side
	muart_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_w),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_bits),
		.empty  (cmd_empty)
	);

	assign cmd       = cmd_t'(cmd_bits);
	assign cmd_valid = ~cmd_empty;

endmodule

### hdl/muart_back.sv
`timescale 1ns / 1ps

module muart_back import muart_pkg::*; #(
	parameter int CHANNELS = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	input  logic      res_full,
	output logic      res_push,
	output out_item_t res
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int EXT_W = (CHANNELS > LINE_W) ? CHANNELS : LINE_W;
	localparam int BATCH = (CHANNELS + 2) / 3;

	// Channel state
	logic [CHANNELS-1:0] prev_line_q, prev_line_d;
	logic [CHANNELS-1:0] slot_q [3];
	logic [CHANNELS-1:0] slot_d [3];
	logic [1:0]          phase_q, phase_d;
	logic [RX_W-1:0]     rx_sh_q [CHANNELS];
	logic [RX_W-1:0]     rx_sh_d [CHANNELS];
	logic [RX_W-1:0]     rx_hold_q [CHANNELS];
	logic [RX_W-1:0]     rx_hold_d [CHANNELS];
	logic [TX_W-1:0]     tx_sh_q [CHANNELS];
	logic [TX_W-1:0]     tx_sh_d [CHANNELS];
	logic [TX_W-1:0]     tx_pend_q [CHANNELS];
	logic [TX_W-1:0]     tx_pend_d [CHANNELS];
	logic [EXT_W-1:0]    accum_q, accum_d;

	// Working signals
	logic                fire;
	logic [IDX_W-1:0]    idx;
	logic [EXT_W-1:0]    line_ext;
	logic [CHANNELS-1:0] line_c;
	logic [1:0]          ph;
	logic [1:0]          nx;
	logic [CHANNELS-1:0] fall;
	logic [CHANNELS-1:0] start;
	logic [CHANNELS-1:0] cur;
	logic [CHANNELS-1:0] finished;
	logic [CHANNELS-1:0] tx_sel;
	logic [RX_W-1:0]     rx_cand [CHANNELS];
	logic [TX_W-1:0]     tx_word [CHANNELS];
	logic [EXT_W-1:0]    acc;
	logic [EXT_W-1:0]    done_ext;

	assign fire     = cmd_valid & ~res_full;
	assign cmd_pop  = fire;
	assign res_push = fire;
	assign idx      = cmd.chan[IDX_W-1:0];

	assign line_ext = EXT_W'(cmd.arg);
	assign line_c   = line_ext[CHANNELS-1:0];
	assign ph       = (phase_q > PHASE_LAST) ? 2'd0 : phase_q;
	assign nx       = (ph == PHASE_LAST) ? 2'd0 : ph + 2'd1;
	assign fall     = ~line_c & prev_line_q;
	assign start    = ~(slot_q[0] | slot_q[1] | slot_q[2]) & fall;
	assign cur      = slot_q[ph];

	// Per-channel candidates: next receive sample, next transmit word
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			rx_cand[i] = {line_c[i], rx_sh_q[i][RX_W-1:1]};
			tx_word[i] = (tx_sh_q[i] == '0) ? tx_pend_q[i] : tx_sh_q[i];
			tx_sel[i]  = (ph == 2'(i / BATCH));
		end
	end

	// Execute one command
	always_comb begin
		prev_line_d = prev_line_q;
		slot_d      = slot_q;
		phase_d     = phase_q;
		rx_sh_d     = rx_sh_q;
		rx_hold_d   = rx_hold_q;
		tx_sh_d     = tx_sh_q;
		tx_pend_d   = tx_pend_q;
		accum_d     = accum_q;
		finished    = '0;
		done_ext    = '0;
		acc         = accum_q;
		res         = '0;
		case (cmd.op)
			OP_TICK: begin
				prev_line_d = line_c;
				// receive: shift in behind the marker, hand over full frames
				for (int i = 0; i < CHANNELS; i++) begin
					if (cur[i]) begin
						if (rx_cand[i][0]) begin
							rx_hold_d[i] = rx_cand[i];
							rx_sh_d[i]   = RX_MARKER;
							finished[i]  = 1'b1;
						end else begin
							rx_sh_d[i] = rx_cand[i];
						end
					end
				end
				slot_d[nx] = slot_q[nx] | start;
				slot_d[ph] = slot_q[ph] & ~finished;
				// transmit: this phase's third of the channels
				for (int i = 0; i < CHANNELS; i++) begin
					if (tx_sel[i]) begin
						if (tx_sh_q[i] == '0) begin
							tx_pend_d[i] = TX_IDLE;
						end
						acc[i]     = acc[i] | tx_word[i][0];
						tx_sh_d[i] = tx_word[i] >> 1;
					end
				end
				phase_d          = nx;
				done_ext         = EXT_W'(finished);
				res.rx_done_mask = done_ext[LINE_W-1:0];
				if (nx == 2'd0) begin
					res.line_out       = acc[LINE_W-1:0];
					res.line_out_valid = 1'b1;
					accum_d            = '0;
				end else begin
					accum_d = acc;
				end
			end
			OP_QUEUE: begin
				tx_pend_d[idx] = {1'b1, cmd.arg[BYTE_W-1:0], 1'b0};
			end
			OP_READ: begin
				rx_hold_d[idx] = '0;
				if (rx_hold_q[idx] != '0) begin
					res.rx_byte  = rx_hold_q[idx][BYTE_W+1:2];
					res.rx_valid = 1'b1;
				end
			end
			OP_QUERY: begin
				res.tx_ready = (tx_pend_q[idx] == TX_IDLE);
			end
			default: begin
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_line_q <= '0;
			phase_q     <= '0;
			accum_q     <= '1;
			for (int p = 0; p < 3; p++) begin
				slot_q[p] <= '0;
			end
			for (int i = 0; i < CHANNELS; i++) begin
				rx_sh_q[i]   <= RX_MARKER;
				rx_hold_q[i] <= '0;
				tx_sh_q[i]   <= '0;
				tx_pend_q[i] <= TX_IDLE;
			end
		end else if (fire) begin
			prev_line_q <= prev_line_d;
			phase_q     <= phase_d;
			accum_q     <= accum_d;
			slot_q      <= slot_d;
			rx_sh_q     <= rx_sh_d;
			rx_hold_q   <= rx_hold_d;
			tx_sh_q     <= tx_sh_d;
			tx_pend_q   <= tx_pend_d;
		end
	end

endmodule

### hdl/multi_uart_transceiver.sv
// Path: a transaction is written into the command queue, executed from its head,
// and its result is written into the result queue. Throughput: one transaction per
// cycle while the result queue has room; every channel's shifters update in
// parallel in the execution stage, which retires one command per cycle.
// Reset: arst_n clears both queues and restores all channel state at once;
// no clearing pass, the block accepts transactions as soon as reset is released.
`timescale 1ns / 1ps

module multi_uart_transceiver import muart_pkg::*; #(
	parameter int CHANNELS = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	cmd_t      cmd;
	logic      cmd_valid;
	logic      cmd_pop;
	logic      res_full;
	logic      res_push;
	out_item_t res;
	logic [$bits(out_item_t)-1:0] res_bits;

	// Front: accept and classify
	muart_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Back: channel state and execution
	muart_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	// Result queue
	muart_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_bits),
		.empty  (empty)
	);

	assign result = out_item_t'(res_bits);

endmodule

### hdl/muart_checker.sv
`timescale 1ns / 1ps
`include "multi_uart_transceiver_assert.svh"

module muart_checker import muart_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      push,
	input logic      full,
	input in_item_t  item,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	// A waiting result holds until it is taken
	`MUART_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(result))

	// Transmit levels are zero unless the phase wrapped
	`MUART_ASSERT_NOW(a_line_out_zero, !empty && !result.line_out_valid, result.line_out == '0)

	// A read that found nothing returns a zero byte
	`MUART_ASSERT_NOW(a_rx_byte_zero, !empty && !result.rx_valid, result.rx_byte == '0)

	// Tick results and request results never mix
	`MUART_ASSERT_NOW(a_kind_exclusive, !empty && (result.line_out_valid || result.rx_done_mask != '0), !result.rx_valid && !result.tx_ready)

endmodule

bind multi_uart_transceiver muart_checker u_checker (.*);
